/* rtl/lkv_pkg.sv */
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic             FUNC_GET   = 1'b0;
  localparam logic             FUNC_PUT   = 1'b1;
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic cap;  // latch compare result for the accepted word
    logic upd;  // apply the update this cycle
    logic hit;  // some valid cell matched the key
    logic put;  // word is a put
  } lkv_ctl_t;

endpackage

/* rtl/lkv_cell.sv */
module lkv_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lkv_pkg::lkv_ctl_t         ctl_i,
  input  logic [lkv_pkg::KEY_W-1:0] cmp_key_i,
  input  logic [lkv_pkg::KEY_W-1:0] prev_key_i,
  input  logic [lkv_pkg::VAL_W-1:0] prev_value_i,
  input  logic                      in_range_i,
  input  logic                      seen_i,
  output logic [lkv_pkg::KEY_W-1:0] key_o,
  output logic [lkv_pkg::VAL_W-1:0] value_o,
  output logic                      valid_o,
  output logic                      seen_o,
  output logic [lkv_pkg::VAL_W-1:0] sel_value_o
);

  logic [lkv_pkg::KEY_W-1:0] key_q;
  logic [lkv_pkg::VAL_W-1:0] value_q;
  logic                      valid_q;
  logic                      match_q;
  logic                      shift;
  logic                      valid_we;

  // Hit: cells up to the matching one shift back. Put miss: cells up to the
  // insert point shift back and the valid row is rebuilt.
  always_comb begin
    if (ctl_i.hit) begin
      shift = ctl_i.upd & ~seen_i;
    end else begin
      shift = ctl_i.upd & ctl_i.put & in_range_i;
    end
    valid_we = ctl_i.upd & ~ctl_i.hit & ctl_i.put;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctl_i.cap) begin
        match_q <= valid_q && (key_q == cmp_key_i);
      end
      if (valid_we) begin
        valid_q <= in_range_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end
  end

  assign key_o       = key_q;
  assign value_o     = value_q;
  assign valid_o     = valid_q;
  assign seen_o      = seen_i | match_q;
  assign sel_value_o = (match_q && !seen_i) ? value_q : '0;

endmodule

/* rtl/lru_key_value_cache.sv */
// Channel  Direction  Handshake             Fields
// in       sink       in_valid_i/in_stall_o  func_i, key_i, put_value_i
// out      source     out_valid_o/out_stall_i hit_o, read_value_o
// cfg      sink       cfg_we_i               cfg_wdata_i (capacity)
//
// For each word, the accept edge compares the key against all cells at once;
// on a hit or put, the update edge shifts the cell row and loads the front cell.
// A get holds in the busy state while the output register is full and
// stalled. Reset empties the store and sets capacity to 16; no clearing pass.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lkv_pkg::CAP_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic signed [lkv_pkg::KEY_W-1:0] key_i,
  input  logic signed [lkv_pkg::VAL_W-1:0] put_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic signed [lkv_pkg::VAL_W-1:0] read_value_o
);

  localparam int FW = $clog2(ENTRIES + 1);
  localparam int CW = (FW > lkv_pkg::CAP_W) ? FW : lkv_pkg::CAP_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                      state_q, state_d;
  logic [lkv_pkg::CAP_W-1:0] capacity_q;
  logic [FW-1:0]             fill_q;
  logic                      func_q;
  logic [lkv_pkg::KEY_W-1:0] key_q;
  logic [lkv_pkg::VAL_W-1:0] put_value_q;
  logic                      out_valid_q;
  logic                      hit_q;
  logic [lkv_pkg::VAL_W-1:0] read_value_q;

  logic                      accept;
  logic                      upd;
  logic                      found;
  logic [lkv_pkg::VAL_W-1:0] hit_value;
  logic [lkv_pkg::VAL_W-1:0] front_value;
  lkv_pkg::lkv_ctl_t         ctl;

  logic [CW-1:0] cap_x, eff_cap, eff_m1, fill_x, newfill_x;
  logic [FW-1:0] newfill;

  logic [lkv_pkg::KEY_W-1:0] cell_key   [ENTRIES+1];
  logic [lkv_pkg::VAL_W-1:0] cell_value [ENTRIES+1];
  logic [ENTRIES:0]          cell_seen;
  logic [lkv_pkg::VAL_W-1:0] sel_value  [ENTRIES];
  logic [ENTRIES-1:0]        cell_valid;
  logic [ENTRIES-1:0]        in_range;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign upd    = (state_q == ST_BUSY) &&
                  !((func_q == lkv_pkg::FUNC_GET) && out_valid_q && out_stall_i);
  assign found  = cell_seen[ENTRIES];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_BUSY;
      ST_BUSY: if (upd) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Insert point of a put miss: min(fill, effective capacity - 1)
  always_comb begin
    cap_x = CW'(capacity_q);
    if (cap_x == '0) begin
      eff_cap = CW'(1);
    end else if (cap_x > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_x;
    end
    eff_m1    = eff_cap - CW'(1);
    fill_x    = CW'(fill_q);
    newfill_x = (fill_x < eff_m1) ? fill_x : eff_m1;
    newfill   = newfill_x[FW-1:0];
  end

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | sel_value[i];
    end
  end

  assign front_value = (func_q == lkv_pkg::FUNC_PUT) ? put_value_q : hit_value;

  assign ctl.cap = accept;
  assign ctl.upd = upd;
  assign ctl.hit = found;
  assign ctl.put = (func_q == lkv_pkg::FUNC_PUT);

  assign cell_key[0]   = key_q;
  assign cell_value[0] = front_value;
  assign cell_seen[0]  = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign in_range[g] = (FW'(g) <= newfill);

    lkv_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .cmp_key_i    (key_i),
      .prev_key_i   (cell_key[g]),
      .prev_value_i (cell_value[g]),
      .in_range_i   (in_range[g]),
      .seen_i       (cell_seen[g]),
      .key_o        (cell_key[g+1]),
      .value_o      (cell_value[g+1]),
      .valid_o      (cell_valid[g]),
      .seen_o       (cell_seen[g+1]),
      .sel_value_o  (sel_value[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      capacity_q  <= lkv_pkg::CAP_RESET;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (upd && !found && (func_q == lkv_pkg::FUNC_PUT)) begin
        fill_q <= newfill + FW'(1);
      end
      if (upd && (func_q == lkv_pkg::FUNC_GET)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q      <= func_i;
      key_q       <= key_i;
      put_value_q <= put_value_i;
    end
    if (upd && (func_q == lkv_pkg::FUNC_GET)) begin
      hit_q        <= found;
      read_value_q <= found ? hit_value : lkv_pkg::MISS_VALUE;
    end
  end

  assign in_stall_o   = (state_q == ST_BUSY);
  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = read_value_q;

  a_result_from_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_BUSY && func_q == lkv_pkg::FUNC_GET))
    else $error("result word without a get");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + ENTRIES'(1))) == '0)
    else $error("valid cells not contiguous from the front");

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(fill_q))
    else $error("fill count disagrees with valid cells");

endmodule

/* dv/tb_top.sv */
module tb_top;

  localparam int          DEPTH       = 16;
  localparam int          N_PHASES    = 8;
  localparam int          PHASE_WORDS = 156;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                      op;
    logic [lkv_pkg::KEY_W-1:0] key;
    logic [lkv_pkg::VAL_W-1:0] data;
  } word_t;

  typedef struct packed {
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] value;
  } read_t;

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              cfg_we_i    = 1'b0;
  logic [lkv_pkg::CAP_W-1:0]         cfg_wdata_i = '0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_stall_o;
  logic                              func_i      = lkv_pkg::FUNC_GET;
  logic signed [lkv_pkg::KEY_W-1:0]  key_i       = '0;
  logic signed [lkv_pkg::VAL_W-1:0]  put_value_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic                              hit_o;
  logic signed [lkv_pkg::VAL_W-1:0]  read_value_o;

  word_t words_to_send [$];
  read_t pending_reads [$];

  logic [lkv_pkg::KEY_W-1:0] cache_key [DEPTH];
  logic [lkv_pkg::VAL_W-1:0] cache_val [DEPTH];
  int unsigned               fill_cnt = 0;
  logic [lkv_pkg::CAP_W-1:0] cap_cfg  = lkv_pkg::CAP_RESET;

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 46;
  int unsigned words_taken   = 0;
  int unsigned reads_seen    = 0;
  int unsigned mismatches    = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned cycle_cnt     = 0;

  word_t                     next_word;
  read_t                     new_read;
  read_t                     want;
  logic                      pred_hit;
  logic [lkv_pkg::VAL_W-1:0] pred_val;

  lru_key_value_cache #(
    .ENTRIES(DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .key_i       (key_i),
    .put_value_i (put_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .read_value_o(read_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [lkv_pkg::KEY_W-1:0] corner_word(input int unsigned sel);
    case (sel)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic int unsigned usable_cells(input logic [lkv_pkg::CAP_W-1:0] c);
    if (c == 0) return 1;
    if (c > DEPTH) return DEPTH;
    return 32'(c);
  endfunction

  function automatic void move_front(input int pos, input logic [lkv_pkg::KEY_W-1:0] k,
                                     input logic [lkv_pkg::VAL_W-1:0] v);
    for (int i = pos; i > 0; i--) begin
      cache_key[i] = cache_key[i-1];
      cache_val[i] = cache_val[i-1];
    end
    cache_key[0] = k;
    cache_val[0] = v;
  endfunction

  // Apply one word to the recency-ordered store; return 1 when it yields a read.
  function automatic bit lru_access(input logic op, input logic [lkv_pkg::KEY_W-1:0] k,
                                    input logic [lkv_pkg::VAL_W-1:0] v, output logic h,
                                    output logic [lkv_pkg::VAL_W-1:0] rv);
    int          pos;
    bit          found;
    int unsigned lim;
    found = 1'b0;
    pos   = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!found && i < fill_cnt && cache_key[i] == k) begin
        found = 1'b1;
        pos   = i;
      end
    end
    h  = found;
    rv = lkv_pkg::MISS_VALUE;
    if (op == lkv_pkg::FUNC_GET) begin
      if (found) begin
        rv = cache_val[pos];
        move_front(pos, k, rv);
      end
      return 1'b1;
    end
    if (found) begin
      move_front(pos, k, v);
      return 1'b0;
    end
    lim = usable_cells(cap_cfg);
    if (fill_cnt >= lim) fill_cnt = lim - 1;
    move_front(fill_cnt, k, v);
    fill_cnt++;
    return 1'b0;
  endfunction

  task automatic push_word(input logic op, input logic [lkv_pkg::KEY_W-1:0] k,
                           input logic [lkv_pkg::VAL_W-1:0] v);
    word_t w;
    w.op   = op;
    w.key  = k;
    w.data = v;
    words_to_send.push_back(w);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        words_taken <= words_taken + 1;
        if (lru_access(func_i, key_i, put_value_i, pred_hit, pred_val)) begin
          new_read.hit   = pred_hit;
          new_read.value = pred_val;
          pending_reads.push_back(new_read);
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = words_to_send.pop_front();
          in_valid_i  <= 1'b1;
          func_i      <= next_word.op;
          key_i       <= next_word.key;
          put_value_i <= next_word.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        reads_seen <= reads_seen + 1;
        if (pending_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read %0d: none expected, got hit=%0b value=%h",
                     reads_seen, hit_o, read_value_o);
        end else begin
          want = pending_reads.pop_front();
          if (want.hit !== hit_o || want.value !== read_value_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("read %0d: expected hit=%0b value=%h, got hit=%0b value=%h",
                       reads_seen, want.hit, want.value, hit_o, read_value_o);
          end
        end
      end
      // hold off once for a long stretch so the cache backs up into its input
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && words_taken >= 500) begin
        hold_left <= 300;
        hold_done <= 1'b1;
      end
      out_stall_i <= (hold_left > 1) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("lru_key_value_cache: mismatch");
      $finish;
    end
  end

  initial begin
    logic [lkv_pkg::CAP_W-1:0] cap_plan [N_PHASES];
    logic [lkv_pkg::KEY_W-1:0] key_pool [$];
    int unsigned               pool_len;
    logic [lkv_pkg::KEY_W-1:0] k;
    logic [lkv_pkg::VAL_W-1:0] v;

    cap_plan = '{5'd3, 5'd1, 5'd16, 5'd0, 5'd31, 5'd6, 5'd2, 5'd16};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_word(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    push_word(lkv_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    push_word(lkv_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    push_word(lkv_pkg::FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_word(lkv_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    push_word(lkv_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    push_word(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    push_word(lkv_pkg::FUNC_GET, 32'h0000_0001, 32'h0000_0000);
    push_word(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    push_word(lkv_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h0000_0005);
    push_word(lkv_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
    push_word(lkv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    push_word(lkv_pkg::FUNC_GET, 32'h7FFF_FFFE, 32'h0000_0000);
    push_word(lkv_pkg::FUNC_PUT, 32'h8000_0001, 32'h1234_5678);
    push_word(lkv_pkg::FUNC_GET, 32'h8000_0001, 32'h0000_0000);
    push_word(lkv_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);

    for (int ph = 0; ph <= N_PHASES; ph++) begin
      // drain everything before touching the capacity
      while (words_to_send.size() != 0 || in_valid_i || pending_reads.size() != 0)
        @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      if (ph == N_PHASES) break;

      send_idle_pct <= (ph < 3) ? 37 : (ph < 6) ? 46 : 0;
      recv_idle_pct <= (ph < 3) ? 46 : (ph < 6) ? 37 : 0;
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= cap_plan[ph];
      cap_cfg      = cap_plan[ph];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;

      while (key_pool.size() > 4) void'(key_pool.pop_front());
      pool_len = usable_cells(cap_plan[ph]) + $urandom_range(1, 6);
      while (key_pool.size() < pool_len) begin
        case ($urandom_range(0, 3))
          0: key_pool.push_back(corner_word($urandom_range(0, 3)));
          1: key_pool.push_back(key_pool.size() == 0 ? $urandom() :
               key_pool[$urandom_range(0, key_pool.size() - 1)] ^
               (32'h1 << $urandom_range(0, 31)));
          default: key_pool.push_back($urandom());
        endcase
      end

      for (int n = 0; n < PHASE_WORDS; n++) begin
        k = ($urandom_range(0, 99) < 85) ?
            key_pool[$urandom_range(0, key_pool.size() - 1)] : $urandom();
        v = ($urandom_range(0, 9) == 0) ? corner_word($urandom_range(0, 3)) : $urandom();
        push_word($urandom_range(0, 1) ? lkv_pkg::FUNC_PUT : lkv_pkg::FUNC_GET, k, v);
      end
    end

    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("lru_key_value_cache: match");
    end else begin
      $display("lru_key_value_cache: mismatch");
    end
    $finish;
  end

endmodule
